// File: sv/dtt_pkg.sv
// Shared types and constants for the deadline timer table.
// No dependencies; dtt_ctrl, dtt_dp and the top level import this package.
package dtt_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ADD_OK     = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL   = 2'd1;
  localparam logic [1:0] KIND_EXPIRED    = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_time;
    logic [31:0] delay_ms;
    logic [7:0]  target_port;
    logic [31:0] byte_count;
    logic [63:0] completion_key;
    logic [63:0] context_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_port;
    logic [31:0] out_bytes;
    logic [63:0] out_key;
    logic [63:0] out_context;
    logic        last_of_run;
  } res_t;

  // 168-bit completion payload kept with each timer
  typedef struct packed {
    logic [7:0]  port;
    logic [31:0] bytes;
    logic [63:0] key;
    logic [63:0] ctx;
  } payload_t;

  typedef struct packed {
    logic [31:0] deadline;
    payload_t    payload;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the accepted request
    logic start;      // begin a tick scan at slot 0
    logic step;       // evaluate the candidate entry
    logic add;        // append (or reject) and post the add result
    logic push_last;  // post the held expiry as the final result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic due;
    logic more;
    logic has_pend;
    logic out_free;
    logic empty;
  } sts_t;

endpackage

// File: sv/dtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/dtt_ctrl.sv
// Sequencer for the deadline timer table: add, tick scan and final flush.
// Depends on dtt_pkg for the command and status structs.
module dtt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_op,
  output logic          req_stall,
  input  dtt_pkg::sts_t sts,
  output dtt_pkg::cmd_t cmd
);
  import dtt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = rst || (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid && !rst) begin
          cmd.latch = 1'b1;
          if (req_op == OP_ADD) begin
            state_next = ST_ADD;
          end else if (!sts.empty) begin
            cmd.start  = 1'b1;
            state_next = ST_EVAL;
          end
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.add    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        // a new expiry can only displace the held one if the output is free
        if (!(sts.due && sts.has_pend && !sts.out_free)) begin
          cmd.step   = 1'b1;
          state_next = sts.more ? ST_EVAL : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.has_pend) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/dtt_dp.sv
// Datapath of the deadline timer table: entry RAM, count, scan index,
// held expiry and output register. Depends on dtt_pkg and dtt_ram.
module dtt_dp #(
  parameter int CAPACITY = dtt_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  dtt_pkg::req_t req_item,
  input  dtt_pkg::cmd_t cmd,
  output dtt_pkg::sts_t sts,
  output logic          res_valid,
  input  logic          res_stall,
  output dtt_pkg::res_t res_item
);
  import dtt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  req_t             req;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic             wb;
  logic             has_pend;
  payload_t         pend;

  entry_t           rdata;
  entry_t           wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic             re;
  logic [IDX_W-1:0] raddr;

  logic             full;
  logic             due;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] idx_ext;
  logic             more_keep;
  logic             more_remove;
  logic             out_free;
  logic             push;
  res_t             res_next;

  assign full        = (count >= CNT_W'(CAPACITY));
  assign due         = !(req.now_time < rdata.deadline);
  assign count_m1    = count - CNT_W'(1);
  assign idx_ext     = CNT_W'(idx);
  assign more_keep   = (idx_ext + CNT_W'(1)) < count;
  assign more_remove = idx_ext < count_m1;
  assign out_free    = !res_valid || !res_stall;

  assign sts.due      = due;
  assign sts.more     = due ? more_remove : more_keep;
  assign sts.has_pend = has_pend;
  assign sts.out_free = out_free;
  assign sts.empty    = (count == '0);

  // RAM ports: appends on add; write-back of a moved entry as its slot is evaluated
  always_comb begin
    we    = (cmd.add && !full) || (cmd.step && wb);
    waddr = cmd.add ? count[IDX_W-1:0] : idx;
    if (cmd.add) begin
      wdata.deadline     = req.now_time + req.delay_ms;
      wdata.payload.port = req.target_port;
      wdata.payload.bytes = req.byte_count;
      wdata.payload.key  = req.completion_key;
      wdata.payload.ctx  = req.context_tag;
    end else begin
      wdata = rdata;
    end
    re    = cmd.start || (cmd.step && sts.more);
    if (cmd.start) begin
      raddr = '0;
    end else if (due) begin
      raddr = count_m1[IDX_W-1:0];
    end else begin
      raddr = idx + IDX_W'(1);
    end
  end

  dtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    push     = cmd.add || (cmd.step && due && has_pend) || cmd.push_last;
    res_next = '0;
    if (cmd.add) begin
      res_next.result_kind = full ? KIND_ADD_FULL : KIND_ADD_OK;
      res_next.last_of_run = 1'b1;
    end else begin
      res_next.result_kind = KIND_EXPIRED;
      res_next.out_port    = pend.port;
      res_next.out_bytes   = pend.bytes;
      res_next.out_key     = pend.key;
      res_next.out_context = pend.ctx;
      res_next.last_of_run = cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= req_item;
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.step && !due) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.start) begin
      wb <= 1'b0;
    end else if (cmd.step) begin
      wb <= due;
    end
    if (cmd.step && due) begin
      pend <= rdata.payload;
    end
    if (push) begin
      res_item <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      has_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.add && !full) begin
        count <= count + CNT_W'(1);
      end else if (cmd.step && due) begin
        count <= count_m1;
      end
      if (cmd.start || cmd.push_last) begin
        has_pend <= 1'b0;
      end else if (cmd.step && due) begin
        has_pend <= 1'b1;
      end
      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/deadline_timer_table.sv
// Deadline timer table, top level: joins the sequencer and the datapath.
// Depends on dtt_pkg, dtt_ctrl, dtt_dp (and dtt_ram below it).
//
// A table of up to CAPACITY pending one-shot timers kept as a packed list
// in a single-read-port RAM. An add request stores deadline = now_time +
// delay_ms (mod 2^32) with its payload at the end of the list and returns
// one result (accepted, or rejected when full). A tick request walks the
// list from slot 0; an entry whose deadline is not above now_time (plain
// unsigned compare) is returned and the last entry is moved into its slot,
// which is then checked again. A tick with nothing due returns no result.
// Requests are handled one at a time. An add is accepted, then, once the
// output register is free, writes the entry and registers its result. A
// tick examines every entry held at the start of the tick once, kept or
// removed, then flushes the held expiry; a tick on an empty table ends at
// its accept. The pace is set by the one RAM read per cycle while the
// output does not stall the scan. Each expiry is held until the next one or
// the flush so that the final one can carry last_of_run; an unread result
// stalls the next add or expiry until the output register frees. No
// clearing pass: only slots below the count are ever read.
module deadline_timer_table #(
  parameter int CAPACITY = dtt_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dtt_pkg::req_t req_item,
  output logic          res_valid,
  input  logic          res_stall,
  output dtt_pkg::res_t res_item
);
  import dtt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one request in flight, decides each scan step
  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req_item.operation),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, compare, and the output register
  dtt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // an add is taken only when the block is free, and keeps it busy
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req_item.operation == OP_ADD)) |=> req_stall)
    else $error("request accepted while another is in flight");

  // a result is only posted into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.add || cmd.push_last || (cmd.step && sts.due && sts.has_pend)) |-> sts.out_free)
    else $error("result posted over an unread result");

  // sequencer never issues two of add, start, step and push_last together
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add, cmd.start, cmd.step, cmd.push_last}))
    else $error("conflicting datapath commands");

endmodule
